/* rtl/core/qdcid_pkg.sv */
`default_nettype none

package qdcid_pkg;

    localparam logic [4:0] MIN_DCID_BYTES = 5'd8;
    localparam logic [4:0] MAX_DCID_BYTES = 5'd20;
    localparam logic [4:0] POS_MAX        = 5'd31;
    localparam logic [4:0] POS_VER_LAST   = 5'd4;
    localparam logic [4:0] POS_DCID_LEN   = 5'd5;
    localparam logic [4:0] POS_DCID_LONG  = 5'd6;

    typedef enum logic [1:0] {
        ST_DECODED = 2'd0,
        ST_NO_INFO = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       first_byte;
        logic       last_byte;
        logic       is_ipv6;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [6:0]  prefix_bits;
        logic [63:0] addr_tail;
        logic [15:0] server_port;
    } t_result;

    typedef struct packed {
        logic [4:0]  pos;
        logic        long_form;
        logic [4:0]  dcid_len;
        logic [3:0]  tail_len;
        logic        has_port;
        logic [7:0]  prev_byte;
        logic [31:0] version;
        logic [63:0] addr;
        logic [15:0] port;
        logic        finished;
    } t_state;

endpackage

`default_nettype wire

/* rtl/core/qdcid_if.sv */
`default_nettype none

interface qdcid_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       first_byte;
    logic       last_byte;
    logic       is_ipv6;

    modport source (output valid, payload_byte, first_byte, last_byte, is_ipv6, input ready);
    modport sink (input valid, payload_byte, first_byte, last_byte, is_ipv6, output ready);
endinterface

interface qdcid_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [6:0]  prefix_bits;
    logic [63:0] addr_tail;
    logic [15:0] server_port;

    modport source (output valid, status, prefix_bits, addr_tail, server_port, input ready);
    modport sink (input valid, status, prefix_bits, addr_tail, server_port, output ready);
endinterface

`default_nettype wire

/* rtl/core/qdcid_step.sv */
`default_nettype none

module qdcid_step
    import qdcid_pkg::*;
(
    input  t_state  i_state,
    input  t_req    i_req,
    output t_state  o_next,
    output logic    o_emit,
    output t_result o_result
);

    function automatic t_status final_check(input t_state s, input logic v6);
        logic [5:0] need_len;
        need_len = {2'b00, s.tail_len} + {4'b0000, s.has_port, 1'b0} + 6'd2;
        if (!v6 && s.tail_len > 4'd4) begin
            return ST_INVALID;
        end
        if (need_len > {1'b0, s.dcid_len}) begin
            return ST_INVALID;
        end
        return ST_DECODED;
    endfunction

    t_state     cur;
    t_state     nxt;
    logic       live;
    logic       decided;
    t_status    st;
    logic [4:0] k;
    logic [4:0] j;
    logic       take;
    logic       long_chk;
    logic       short_chk;
    logic [7:0] b;
    logic [7:0] d;
    logic [4:0] need;

    always_comb begin
        b         = i_req.payload_byte;
        cur       = i_req.first_byte ? '0 : i_state;
        live      = i_req.first_byte || (!i_state.finished && i_state.pos != '0);
        nxt       = cur;
        decided   = 1'b0;
        st        = ST_DECODED;
        k         = '0;
        take      = 1'b0;
        long_chk  = 1'b0;
        short_chk = 1'b0;
        j         = '0;
        d         = {cur.prev_byte[3:0], b[7:4]};
        need      = '0;

        if (cur.pos == '0) begin
            nxt.long_form = b[7];
            if (!b[6]) begin
                decided = 1'b1;
                st      = ST_INVALID;
            end
        end else if (cur.long_form) begin
            if (cur.pos <= POS_VER_LAST) begin
                nxt.version = {cur.version[23:0], b};
                if (cur.pos == POS_VER_LAST && nxt.version > 32'd1) begin
                    decided = 1'b1;
                    st      = ST_INVALID;
                end
            end else if (cur.pos == POS_DCID_LEN) begin
                if (b > {3'b000, MAX_DCID_BYTES}) begin
                    decided = 1'b1;
                    st      = ST_INVALID;
                end else if (b < {3'b000, MIN_DCID_BYTES}) begin
                    decided = 1'b1;
                    st      = ST_NO_INFO;
                end else begin
                    nxt.dcid_len = b[4:0];
                end
            end else begin
                k        = cur.pos - POS_DCID_LONG;
                take     = 1'b1;
                long_chk = 1'b1;
            end
        end else begin
            k         = cur.pos - 5'd1;
            take      = 1'b1;
            short_chk = (k != '0);
        end

        // DCID byte 1 holds tail length and port flag; later bytes carry nibble-shifted data
        if (take) begin
            if (k == 5'd1) begin
                nxt.tail_len = {1'b0, b[7:5]} + 4'd1;
                nxt.has_port = b[4];
            end else if (k >= 5'd2) begin
                j = k - 5'd2;
                if (j < {1'b0, cur.tail_len}) begin
                    nxt.addr = {cur.addr[55:0], d};
                end else if (cur.has_port && j < ({1'b0, cur.tail_len} + 5'd2)) begin
                    nxt.port = {cur.port[7:0], d};
                end
            end
        end

        if (short_chk && k == 5'd1) begin
            nxt.dcid_len = {3'b000, b[6:5]} + 5'd1 + (b[4] ? 5'd2 : 5'd0) + 5'd6;
        end

        if (long_chk && ({1'b0, k} + 6'd1) == {1'b0, nxt.dcid_len}) begin
            decided = 1'b1;
            st      = final_check(nxt, i_req.is_ipv6);
        end

        if (short_chk) begin
            need = (nxt.dcid_len > MIN_DCID_BYTES) ? nxt.dcid_len : MIN_DCID_BYTES;
            if (({1'b0, k} + 6'd1) == {1'b0, need}) begin
                decided = 1'b1;
                st      = final_check(nxt, i_req.is_ipv6);
            end
        end

        nxt.prev_byte = b;
        nxt.pos       = (cur.pos < POS_MAX) ? cur.pos + 5'd1 : POS_MAX;

        // packet closed without a verdict
        if (!decided && i_req.last_byte) begin
            decided = 1'b1;
            st      = nxt.long_form ? ST_INVALID : ST_NO_INFO;
        end

        if (decided) begin
            nxt.finished = 1'b1;
        end

        o_result.status = st;
        if (st == ST_DECODED) begin
            o_result.prefix_bits = {nxt.tail_len, 3'b000};
            o_result.addr_tail   = nxt.addr;
            o_result.server_port = nxt.has_port ? nxt.port : 16'd0;
        end else begin
            o_result.prefix_bits = '0;
            o_result.addr_tail   = '0;
            o_result.server_port = '0;
        end

        o_emit = live && decided;
        o_next = live ? nxt : i_state;
    end

endmodule

`default_nettype wire

/* rtl/core/quic_dcid_server_decoder.sv */
// The result is registered into the output queue when the byte that settles the verdict is accepted.
// Throughput: one payload byte per cycle; the decode step is a single pass of logic.
// A two-entry output queue keeps input flowing while a result waits; input stalls only
// when both entries are full.
// Reset (synchronous, active low) clears the decode state and empties the output queue.
`default_nettype none

module quic_dcid_server_decoder
    import qdcid_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    qdcid_req_if.sink   i_req,
    qdcid_rsp_if.source o_rsp
);

    t_state  r_state;
    t_state  n_state;
    t_req    req;
    t_result step_result;
    logic    step_emit;
    t_result r_out;
    logic    r_out_valid;
    t_result r_skid;
    logic    r_skid_valid;
    logic    accept;
    logic    push;
    logic    pop;

    assign req = {i_req.payload_byte, i_req.first_byte, i_req.last_byte, i_req.is_ipv6};

    assign i_req.ready = !r_skid_valid;
    assign accept      = i_req.valid && !r_skid_valid;

    qdcid_step u_step (
        .i_state  (r_state),
        .i_req    (req),
        .o_next   (n_state),
        .o_emit   (step_emit),
        .o_result (step_result)
    );

    assign push = accept && step_emit;
    assign pop  = r_out_valid && o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= n_state;
            end
            if (r_skid_valid) begin
                // drain the skid entry into the output slot
                if (pop) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end
            end else if (push) begin
                if (!r_out_valid || pop) begin
                    r_out       <= step_result;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= step_result;
                    r_skid_valid <= 1'b1;
                end
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.prefix_bits = r_out.prefix_bits;
    assign o_rsp.addr_tail   = r_out.addr_tail;
    assign o_rsp.server_port = r_out.server_port;

endmodule

`default_nettype wire

/* rtl/core/qdcid_checker.sv */
`default_nettype none

module qdcid_checker
    import qdcid_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [1:0]  i_status,
    input wire [6:0]  i_prefix_bits,
    input wire [63:0] i_addr_tail,
    input wire [15:0] i_server_port
);

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == ST_DECODED || i_status == ST_NO_INFO
                         || i_status == ST_INVALID))
        else $error("undefined status code");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status != ST_DECODED) |->
        (i_prefix_bits == 7'd0 && i_addr_tail == 64'd0 && i_server_port == 16'd0))
        else $error("non-decoded request carries address data");

    a_prefix_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == ST_DECODED) |->
        (i_prefix_bits[2:0] == 3'd0 && i_prefix_bits != 7'd0 && i_prefix_bits <= 7'd64))
        else $error("decoded prefix length out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_status) && $stable(i_addr_tail) && $stable(i_server_port)))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind quic_dcid_server_decoder qdcid_checker u_qdcid_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_status      (o_rsp.status),
    .i_prefix_bits (o_rsp.prefix_bits),
    .i_addr_tail   (o_rsp.addr_tail),
    .i_server_port (o_rsp.server_port)
);

`default_nettype wire
